/* rtl/rrts_pkg.sv */
// shared codes and control types of the round-robin thread scheduler
package rrts_pkg;

    // opcodes of a scheduler request
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_YIELD  = 3'd2;
    localparam logic [2:0] OP_JOIN   = 3'd3;
    localparam logic [2:0] OP_EXIT   = 3'd4;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_SLOT   = 2'd1;
    localparam logic [1:0] STS_JOIN_FREE = 2'd2;
    localparam logic [1:0] STS_NO_RUN    = 2'd3;

    // slot state codes, held as two bit planes
    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;
    localparam logic [1:0] SLOT_SLEEPING = 2'd3;

    // status of the shared slot scanner
    typedef struct packed {
        logic active;
        logic hit;
        logic miss;
    } t_scan_sts;

    // strobes into the wait matrix memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
        logic clr_all;
    } t_wmem_ctl;

endpackage

/* rtl/round_robin_thread_scheduler_top.sv */
// round-robin thread scheduler with join: sequencer, slot table and result register
//
// Requests arrive on the s channel (opcode, target slot) and each one gives one
// result on the m channel (status, created slot, running slot and flags).
// o_s_tready is high only while the sequencer is idle; one request is worked at a
// time. All slot searches go through one shared scanner that tests one slot per
// cycle, and the wait matrix is a memory read one row per cycle. Init and rejected
// requests go straight to the result state; create runs a free-slot scan, yield a
// scan for the next runnable slot, join a read-modify-write of the wait row and then
// that scan, and exit a wake pass over all rows and then that scan. The next request
// is taken only once a result has been loaded and the sequencer is back in idle.
// The result waits in an output register; a new request is taken while it waits,
// and a finished request holds in its result state until the register frees up.
// Reset leaves every slot free, every first-run flag set, the wait matrix empty
// and no thread current; the m channel comes out of reset empty.
module round_robin_thread_scheduler_top #(
    parameter int THREADS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] opcode, [6:3] target_thread, [7] zero
    input  logic [7:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [5:2] created_thread, [9:6] running_thread,
    // [10] running_valid, [11] fresh_start, [12] switched, [15:13] zero
    output logic [15:0] o_m_tdata
);
    import rrts_pkg::*;

    localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CW = $clog2(THREADS + 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FREE_SCAN = 8'b0000_0010,
        S_JOIN_RD   = 8'b0000_0100,
        S_JOIN_WR   = 8'b0000_1000,
        S_WAKE      = 8'b0001_0000,
        S_WAKE_TAIL = 8'b0010_0000,
        S_RUN_SCAN  = 8'b0100_0000,
        S_RESP      = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [IW-1:0]      r_tgt, n_tgt;
    logic [IW-1:0]      r_cur, n_cur;
    logic               r_cval, n_cval;
    logic [IW-1:0]      r_old_cur, n_old_cur;
    logic               r_old_val, n_old_val;
    logic [1:0]         r_status, n_status;
    logic [IW-1:0]      r_created, n_created;
    logic               r_fresh, n_fresh;
    logic [THREADS-1:0] r_lo, n_lo;
    logic [THREADS-1:0] r_hi, n_hi;
    logic [THREADS-1:0] r_first, n_first;
    logic               r_m_valid, n_m_valid;
    logic [15:0]        r_m_data, n_m_data;

    logic               w_accept;
    logic [2:0]         w_in_op;
    logic [3:0]         w_in_tgt;
    logic [IW-1:0]      w_tgt_idx;
    logic               w_tgt_ok;
    logic [IW-1:0]      w_next_base;
    logic [THREADS-1:0] w_free;
    logic [THREADS-1:0] w_runnable;
    logic [THREADS-1:0] w_cur_mask;
    logic [THREADS-1:0] w_tgt_mask;
    logic [THREADS-1:0] w_row_clr;
    logic               w_sw;

    logic               scan_start;
    logic [IW-1:0]      scan_base;
    logic [CW-1:0]      scan_count;
    logic [THREADS-1:0] scan_match;
    logic [IW-1:0]      scan_idx;
    t_scan_sts          scan_sts;

    t_wmem_ctl          mem_ctl;
    logic [IW-1:0]      mem_rd_addr;
    logic [IW-1:0]      mem_wr_addr;
    logic [THREADS-1:0] mem_wr_data;
    logic [IW-1:0]      mem_clr_addr;
    logic               mem_rd_ack;
    logic [IW-1:0]      mem_rd_row;
    logic [THREADS-1:0] mem_rd_data;

    // request decode
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_op    = i_s_tdata[2:0];
    assign w_in_tgt   = i_s_tdata[6:3];
    assign w_tgt_idx  = IW'(w_in_tgt);
    assign w_tgt_ok   = (32'(w_in_tgt) < 32'(THREADS));

    // slot table views
    assign w_free      = ~(r_lo | r_hi);
    assign w_runnable  = r_lo & ~r_hi;
    assign w_cur_mask  = {{(THREADS-1){1'b0}}, 1'b1} << r_cur;
    assign w_tgt_mask  = {{(THREADS-1){1'b0}}, 1'b1} << r_tgt;
    assign w_row_clr   = mem_rd_data & ~w_cur_mask;
    assign w_next_base = (r_cur == IW'(THREADS - 1)) ? '0 : r_cur + IW'(1);

    // switch flag against the state seen at acceptance
    assign w_sw = (r_old_val != r_cval) || (r_cval && (r_old_cur != r_cur));

    // scanner match source follows the sequencer state
    always_comb begin
        case (r_state)
            S_FREE_SCAN: scan_match = w_free;
            S_RUN_SCAN:  scan_match = w_runnable;
            default:     scan_match = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_tgt        = r_tgt;
        n_cur        = r_cur;
        n_cval       = r_cval;
        n_old_cur    = r_old_cur;
        n_old_val    = r_old_val;
        n_status     = r_status;
        n_created    = r_created;
        n_fresh      = r_fresh;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_first      = r_first;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        scan_start   = 1'b0;
        scan_base    = '0;
        scan_count   = CW'(THREADS);
        mem_ctl      = '0;
        mem_rd_addr  = scan_idx;
        mem_wr_addr  = mem_rd_row;
        mem_wr_data  = w_row_clr;
        mem_clr_addr = r_cur;

        // output register drains on its own handshake
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = w_in_op;
                    n_tgt     = w_tgt_idx;
                    n_old_cur = r_cur;
                    n_old_val = r_cval;
                    n_status  = STS_OK;
                    n_created = '0;
                    n_fresh   = 1'b0;
                    n_state   = S_RESP;
                    case (w_in_op)
                        OP_INIT: begin
                            n_lo           = '0;
                            n_hi           = '0;
                            n_first        = '1;
                            n_first[0]     = 1'b0;
                            n_lo[0]        = SLOT_RUNNING[0];
                            n_hi[0]        = SLOT_RUNNING[1];
                            n_cur          = '0;
                            n_cval         = 1'b1;
                            mem_ctl.clr_all = 1'b1;
                        end
                        OP_CREATE: begin
                            scan_start = 1'b1;
                            scan_base  = '0;
                            scan_count = CW'(THREADS);
                            n_state    = S_FREE_SCAN;
                        end
                        OP_YIELD, OP_JOIN, OP_EXIT: begin
                            if (!r_cval) begin
                                n_status = STS_NO_RUN;
                            end else if (w_in_op == OP_YIELD) begin
                                scan_start = 1'b1;
                                scan_base  = w_next_base;
                                scan_count = CW'(THREADS - 1);
                                n_state    = S_RUN_SCAN;
                            end else if (w_in_op == OP_JOIN) begin
                                if (!w_tgt_ok ||
                                    ({r_hi[w_tgt_idx], r_lo[w_tgt_idx]} == SLOT_FREE)) begin
                                    n_status = STS_JOIN_FREE;
                                end else begin
                                    n_lo[r_cur] = SLOT_SLEEPING[0];
                                    n_hi[r_cur] = SLOT_SLEEPING[1];
                                    n_state     = S_JOIN_RD;
                                end
                            end else begin
                                scan_start = 1'b1;
                                scan_base  = '0;
                                scan_count = CW'(THREADS);
                                n_state    = S_WAKE;
                            end
                        end
                        default: begin
                            n_status = STS_OK;
                        end
                    endcase
                end
            end

            // lowest free slot for create
            S_FREE_SCAN: begin
                if (scan_sts.hit) begin
                    n_lo[scan_idx]    = SLOT_RUNNABLE[0];
                    n_hi[scan_idx]    = SLOT_RUNNABLE[1];
                    n_first[scan_idx] = 1'b1;
                    n_created         = scan_idx;
                    mem_ctl.clr_en    = 1'b1;
                    mem_clr_addr      = scan_idx;
                    n_state           = S_RESP;
                end else if (scan_sts.miss) begin
                    n_status = STS_NO_SLOT;
                    n_state  = S_RESP;
                end
            end

            // read-modify-write of the caller's wait row
            S_JOIN_RD: begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = r_cur;
                n_state       = S_JOIN_WR;
            end

            S_JOIN_WR: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = r_cur;
                mem_wr_data   = mem_rd_data | w_tgt_mask;
                scan_start    = 1'b1;
                scan_base     = w_next_base;
                scan_count    = CW'(THREADS - 1);
                n_state       = S_RUN_SCAN;
            end

            // wake pass: one row read per cycle, each row written back when its registered read returns
            S_WAKE, S_WAKE_TAIL: begin
                if (r_state == S_WAKE) begin
                    mem_ctl.rd_en = scan_sts.active;
                    if (scan_sts.miss) begin
                        n_state = S_WAKE_TAIL;
                    end
                end else begin
                    scan_start = 1'b1;
                    scan_base  = w_next_base;
                    scan_count = CW'(THREADS - 1);
                    n_state    = S_RUN_SCAN;
                end
                if (mem_rd_ack && mem_rd_data[r_cur]) begin
                    mem_ctl.wr_en = 1'b1;
                    if ((w_row_clr == '0) &&
                        ({r_hi[mem_rd_row], r_lo[mem_rd_row]} == SLOT_SLEEPING)) begin
                        n_lo[mem_rd_row] = SLOT_RUNNABLE[0];
                        n_hi[mem_rd_row] = SLOT_RUNNABLE[1];
                    end
                end
            end

            // next runnable slot after the current one
            S_RUN_SCAN: begin
                if (scan_sts.hit || scan_sts.miss) begin
                    n_state = S_RESP;
                    if (r_op == OP_EXIT) begin
                        n_lo[r_cur]    = SLOT_FREE[0];
                        n_hi[r_cur]    = SLOT_FREE[1];
                        n_first[r_cur] = 1'b1;
                        mem_ctl.clr_en = 1'b1;
                        mem_clr_addr   = r_cur;
                        if (scan_sts.miss) begin
                            n_cval = 1'b0;
                            n_cur  = '0;
                        end
                    end else if (scan_sts.hit &&
                                 ({r_hi[r_cur], r_lo[r_cur]} == SLOT_RUNNING)) begin
                        n_lo[r_cur] = SLOT_RUNNABLE[0];
                        n_hi[r_cur] = SLOT_RUNNABLE[1];
                    end
                    if (scan_sts.hit) begin
                        n_cur          = scan_idx;
                        n_cval         = 1'b1;
                        n_lo[scan_idx] = SLOT_RUNNING[0];
                        n_hi[scan_idx] = SLOT_RUNNING[1];
                        if (r_first[scan_idx]) begin
                            n_fresh           = 1'b1;
                            n_first[scan_idx] = 1'b0;
                        end
                    end
                end
            end

            // load the result register once it is free
            S_RESP: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {3'b000, w_sw, r_fresh, r_cval,
                                 (r_cval ? 4'(r_cur) : 4'd0), 4'(r_created), r_status};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and slot table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_cval    <= 1'b0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_first   <= '1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_cval    <= n_cval;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_first   <= n_first;
            r_m_valid <= n_m_valid;
        end
    end

    // request payload and result registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_tgt     <= n_tgt;
        r_old_cur <= n_old_cur;
        r_old_val <= n_old_val;
        r_status  <= n_status;
        r_created <= n_created;
        r_fresh   <= n_fresh;
        r_m_data  <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // shared slot scanner
    rrts_scan #(
        .THREADS (THREADS),
        .IW      (IW),
        .CW      (CW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_base  (scan_base),
        .i_count (scan_count),
        .i_match (scan_match),
        .o_idx   (scan_idx),
        .o_sts   (scan_sts)
    );

    // wait matrix
    rrts_wait_mem #(
        .THREADS (THREADS),
        .IW      (IW)
    ) u_wait_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_rd_addr  (mem_rd_addr),
        .i_wr_addr  (mem_wr_addr),
        .i_wr_data  (mem_wr_data),
        .i_clr_addr (mem_clr_addr),
        .o_rd_ack   (mem_rd_ack),
        .o_rd_addr  (mem_rd_row),
        .o_rd_data  (mem_rd_data)
    );

endmodule

/* rtl/rrts_scan.sv */
// shared slot scanner: steps one slot per cycle with wrap and tests a match vector
module rrts_scan #(
    parameter int THREADS = 16,
    parameter int IW      = 4,
    parameter int CW      = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [IW-1:0]          i_base,
    input  logic [CW-1:0]          i_count,
    input  logic [THREADS-1:0]     i_match,
    output logic [IW-1:0]          o_idx,
    output rrts_pkg::t_scan_sts    o_sts
);
    import rrts_pkg::*;

    logic          r_act;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic          w_hit;
    logic          w_miss;
    logic [IW-1:0] w_idx_next;

    // match test at the current slot
    assign w_hit  = r_act && i_match[r_idx];
    assign w_miss = r_act && !i_match[r_idx] && (r_left == CW'(1));

    // wrapping slot increment
    assign w_idx_next = (r_idx == IW'(THREADS - 1)) ? '0 : r_idx + IW'(1);

    // scan progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_start) begin
            r_act <= 1'b1;
        end else if (w_hit || w_miss) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx  <= i_base;
            r_left <= i_count;
        end else if (r_act) begin
            r_idx  <= w_idx_next;
            r_left <= r_left - CW'(1);
        end
    end

    assign o_idx        = r_idx;
    assign o_sts.active = r_act;
    assign o_sts.hit    = w_hit;
    assign o_sts.miss   = w_miss;

endmodule

/* rtl/rrts_wait_mem.sv */
// wait matrix memory, one row per slot, with a valid bit per row
module rrts_wait_mem #(
    parameter int THREADS = 16,
    parameter int IW      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrts_pkg::t_wmem_ctl  i_ctl,
    input  logic [IW-1:0]        i_rd_addr,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [THREADS-1:0]   i_wr_data,
    input  logic [IW-1:0]        i_clr_addr,
    output logic                 o_rd_ack,
    output logic [IW-1:0]        o_rd_addr,
    output logic [THREADS-1:0]   o_rd_data
);
    import rrts_pkg::*;

    logic [THREADS-1:0] r_mem [THREADS];
    logic [THREADS-1:0] r_vld;
    logic [THREADS-1:0] r_rd_data;
    logic               r_rd_ok;
    logic               r_rd_ack;
    logic [IW-1:0]      r_rd_addr;

    // row valid bits, a row that is not valid reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr_all) begin
            r_vld <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_vld[i_clr_addr] <= 1'b0;
            end
        end
    end

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= r_vld[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ack <= 1'b0;
        end else begin
            r_rd_ack <= i_ctl.rd_en;
        end
    end

    assign o_rd_ack  = r_rd_ack;
    assign o_rd_addr = r_rd_addr;
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule
